### src/mmst_pkg.sv
// ----------------------------------------------------------------------------
// mmst_pkg
// shared widths, operation and status codes, and control structs for the
// bounded multiset with minimum, maximum and sum
// ----------------------------------------------------------------------------
package mmst_pkg;

    localparam int OP_W  = 2;
    localparam int VAL_W = 32;
    localparam int ST_W  = 2;
    localparam int SUM_W = 40;
    localparam int OCC_W = 9;

    // operation codes
    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;

    // result status codes
    localparam logic [ST_W-1:0] ST_APPLIED = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL    = 2'd1;
    localparam logic [ST_W-1:0] ST_ABSENT  = 2'd2;
    localparam logic [ST_W-1:0] ST_QUERY   = 2'd3;

    typedef logic [OP_W-1:0]         t_op;
    typedef logic signed [VAL_W-1:0] t_value;
    typedef logic [ST_W-1:0]         t_status;
    typedef logic signed [SUM_W-1:0] t_sum;
    typedef logic [OCC_W-1:0]        t_occ;

    // controller to datapath
    typedef struct packed {
        logic capture;  // register item and per-cell compare flags
        logic apply;    // shift the chain, update count and sum
        logic load;     // form the result into the output register
    } t_dp_cmd;

    // datapath to checks
    typedef struct packed {
        logic empty;
        logic full;
    } t_dp_stat;

endpackage

### src/mmst_if.sv
// ----------------------------------------------------------------------------
// mmst interfaces
// valid/ready channels for the item beat and the result beat
// ----------------------------------------------------------------------------
interface mmst_in_if
    import mmst_pkg::*;
    ();
    logic   valid;
    logic   ready;
    t_op    operation;
    t_value value;

    modport source (output valid, output operation, output value, input ready);
    modport sink   (input valid, input operation, input value, output ready);
endinterface

interface mmst_out_if
    import mmst_pkg::*;
    ();
    logic    valid;
    logic    ready;
    t_status status;
    t_value  smallest;
    t_value  largest;
    t_sum    total;
    t_occ    occupancy;
    logic    is_empty;

    modport source (
        output valid, output status, output smallest, output largest,
        output total, output occupancy, output is_empty, input ready
    );
    modport sink (
        input valid, input status, input smallest, input largest,
        input total, input occupancy, input is_empty, output ready
    );
endinterface

### src/multiset_min_max_sum_table.sv
// ----------------------------------------------------------------------------
// multiset_min_max_sum_table
// bounded sorted multiset of signed values with minimum, maximum and sum
// ----------------------------------------------------------------------------
// sequence: an accepted item beat is captured, then applied to the chain (shift),
//   then its result is formed into the result register; forming waits while the
//   result register is still held by a stalled sink
// no new item beat is taken until the result of the last one has been formed
// reset: synchronous active low; count and sum clear, cells are not cleared
// ----------------------------------------------------------------------------
module multiset_min_max_sum_table
    import mmst_pkg::*;
#(
    parameter int CAPACITY = 256
)
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    mmst_in_if.sink     i_in,
    mmst_out_if.source  o_out
);

    t_dp_cmd  cmd;
    t_dp_stat stat;
    logic     in_ready;
    logic     out_valid;

    // sequencer: one item in flight, result register parts the sink side
    mmst_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid),
        .i_out_ready (o_out.ready),
        .o_cmd       (cmd)
    );

    // chain of cells kept in ascending order, compared in parallel
    mmst_datapath #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_operation (i_in.operation),
        .i_value     (i_in.value),
        .o_status    (o_out.status),
        .o_smallest  (o_out.smallest),
        .o_largest   (o_out.largest),
        .o_total     (o_out.total),
        .o_occupancy (o_out.occupancy),
        .o_is_empty  (o_out.is_empty)
    );

    assign i_in.ready  = in_ready;
    assign o_out.valid = out_valid;

    // an accepted beat is applied to the chain on the very next cycle
    a_accept_then_apply : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> cmd.apply)
        else $error("accepted beat not applied on the following cycle");

    // no new beat is taken while a shift or result forming is pending
    a_no_overlap : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.apply || cmd.load) |-> !i_in.ready)
        else $error("input ready while an item is still in flight");

    // empty and full exclude each other
    a_empty_full : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(stat.empty && stat.full))
        else $error("set reported both empty and full");

    // an empty result carries the empty markers
    a_empty_result : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.is_empty) |->
            (o_out.smallest == -32'sd1 && o_out.largest == -32'sd1 && o_out.total == '0))
        else $error("empty result with wrong minimum, maximum or sum");

endmodule

### src/mmst_ctrl.sv
// ----------------------------------------------------------------------------
// mmst_ctrl
// item sequencer: capture, apply, form result; owns both handshakes
// ----------------------------------------------------------------------------
module mmst_ctrl
    import mmst_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    output t_dp_cmd  o_cmd
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_APPLY = 2'd1;
    localparam logic [1:0] S_FORM  = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       out_free;

    assign out_free   = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_APPLY;
                end
            end
            S_APPLY: begin
                o_cmd.apply = 1'b1;
                n_state     = S_FORM;
            end
            S_FORM: begin
                // wait here while the previous result is still held
                if (out_free) begin
                    o_cmd.load  = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

### src/mmst_datapath.sv
// ----------------------------------------------------------------------------
// mmst_datapath
// sorted chain of cells with count, running sum and result register
// ----------------------------------------------------------------------------
module mmst_datapath
    import mmst_pkg::*;
#(
    parameter int CAPACITY = 256
)
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_dp_cmd  i_cmd,
    output t_dp_stat o_stat,
    input  t_op      i_operation,
    input  t_value   i_value,
    output t_status  o_status,
    output t_value   o_smallest,
    output t_value   o_largest,
    output t_sum     o_total,
    output t_occ     o_occupancy,
    output logic     o_is_empty
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    t_value r_cell [CAPACITY];
    t_value n_cell [CAPACITY];

    logic [CAPACITY-1:0] r_valid;
    logic [CAPACITY-1:0] r_gt;
    logic [CAPACITY-1:0] r_ge;
    logic [CAPACITY-1:0] r_eq;
    logic [CAPACITY-1:0] last;

    t_op              r_op;
    t_value           r_value;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    t_sum             r_sum;
    t_sum             n_sum;
    t_status          r_status_pend;
    t_status          n_status_pend;

    t_status          r_status;
    t_value           r_smallest;
    t_value           r_largest;
    t_sum             r_total;
    t_occ             r_occupancy;
    logic             r_is_empty;

    logic   empty;
    logic   full;
    logic   found;
    logic   do_ins;
    logic   do_rem;
    t_value top_sel;

    assign empty = (r_count == '0);
    assign full  = (r_count == CNT_W'(CAPACITY));
    assign found = |(r_valid & r_eq);

    assign do_ins = i_cmd.apply && (r_op == OP_INSERT) && !full;
    assign do_rem = i_cmd.apply && (r_op == OP_REMOVE) && found;

    assign o_stat.empty = empty;
    assign o_stat.full  = full;

    // per-cell compare flags, registered at capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op    <= i_operation;
            r_value <= i_value;
            for (int i = 0; i < CAPACITY; i++) begin
                r_valid[i] <= (r_count > CNT_W'(i));
                r_gt[i]    <= (r_cell[i] >  i_value);
                r_ge[i]    <= (r_cell[i] >= i_value);
                r_eq[i]    <= (r_cell[i] == i_value);
            end
        end
    end

    // cell update: insert opens a gap at the first larger cell,
    // remove pulls every cell at or above the value one place down
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic keep_ins;
        logic take_new;
        logic pull_rem;

        assign keep_ins = r_valid[g] && !r_gt[g];

        if (g == 0) begin : g_first
            assign take_new = 1'b1;
        end else begin : g_rest
            assign take_new = !(r_valid[g-1] && r_gt[g-1]);
        end

        if (g == CAPACITY - 1) begin : g_tail
            assign pull_rem = 1'b0;
        end else begin : g_body
            assign pull_rem = r_valid[g] && r_ge[g];
        end

        always_comb begin
            n_cell[g] = r_cell[g];
            if (do_ins && !keep_ins) begin
                if (take_new) begin
                    n_cell[g] = r_value;
                end else begin
                    n_cell[g] = r_cell[(g == 0) ? 0 : g - 1];
                end
            end else if (do_rem && pull_rem) begin
                n_cell[g] = r_cell[(g == CAPACITY - 1) ? g : g + 1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (do_ins || do_rem) begin
                r_cell[g] <= n_cell[g];
            end
        end

        assign last[g] = (r_count == CNT_W'(g + 1));
    end

    // count, sum and status
    always_comb begin
        n_count       = r_count;
        n_sum         = r_sum;
        n_status_pend = ST_QUERY;
        unique case (r_op)
            OP_INSERT: begin
                n_status_pend = full ? ST_FULL : ST_APPLIED;
            end
            OP_REMOVE: begin
                n_status_pend = found ? ST_APPLIED : ST_ABSENT;
            end
            default: begin
                n_status_pend = ST_QUERY;
            end
        endcase
        if (do_ins) begin
            n_count = r_count + CNT_W'(1);
            n_sum   = r_sum + SUM_W'(r_value);
        end else if (do_rem) begin
            n_count = r_count - CNT_W'(1);
            n_sum   = r_sum - SUM_W'(r_value);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_sum   <= '0;
        end else if (i_cmd.apply) begin
            r_count <= n_count;
            r_sum   <= n_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.apply) begin
            r_status_pend <= n_status_pend;
        end
    end

    // one-hot select of the highest occupied cell
    always_comb begin
        top_sel = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            top_sel = top_sel | (r_cell[i] & {VAL_W{last[i]}});
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_status    <= r_status_pend;
            r_smallest  <= empty ? t_value'(-1) : r_cell[0];
            r_largest   <= empty ? t_value'(-1) : top_sel;
            r_total     <= r_sum;
            r_occupancy <= OCC_W'(r_count);
            r_is_empty  <= empty;
        end
    end

    assign o_status    = r_status;
    assign o_smallest  = r_smallest;
    assign o_largest   = r_largest;
    assign o_total     = r_total;
    assign o_occupancy = r_occupancy;
    assign o_is_empty  = r_is_empty;

endmodule
